/* hw/rtl/rtt_timeout_estimator_assert.svh */
// ----------------------------------------------------------------------------
// rtt_timeout_estimator_assert.svh
// Assertion macros shared by the rtt timeout estimator
// ----------------------------------------------------------------------------
`ifndef RTT_TIMEOUT_ESTIMATOR_ASSERT_SVH
`define RTT_TIMEOUT_ESTIMATOR_ASSERT_SVH

// same-cycle implication, off while reset is high
`define RTTE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define RTTE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/rtte_pkg.sv */
// ----------------------------------------------------------------------------
// rtte_pkg
// Types, constants and helpers shared by the rtt timeout estimator
// ----------------------------------------------------------------------------
package rtte_pkg;

   localparam int GAIN_W    = 17;
   localparam int GAIN_FRAC = 16;
   localparam int MULT_W    = 16;
   localparam int MULT_FRAC = 8;
   localparam int MS_W      = 32;
   localparam int TOTAL_W   = 64;
   localparam int MUL_CHUNK = 16;
   localparam int PROD_W    = MUL_CHUNK + GAIN_W;
   // integer part of the timeout sum before clamping
   localparam int RAW_W     = MS_W + GAIN_W - MULT_FRAC;

   localparam logic [GAIN_W-1:0] GAIN_ONE     = GAIN_W'(1 << GAIN_FRAC);
   localparam logic [GAIN_W-1:0] SMOOTH_SCALE = GAIN_W'(1 << MULT_FRAC);

   localparam int DIV_STEPS = TOTAL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VAR_MULT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TIMEOUT = 3'd4;

   localparam logic [GAIN_W-1:0] ALPHA_RESET = 17'd8192;
   localparam logic [GAIN_W-1:0] BETA_RESET  = 17'd16384;
   localparam logic [MULT_W-1:0] MULT_RESET  = 16'd1024;
   localparam logic [MS_W-1:0]   MIN_RESET   = 32'd1000;
   localparam logic [MS_W-1:0]   MAX_RESET   = 32'd60000;

   typedef enum logic [1:0] {
      DOT_VAR,
      DOT_SRTT,
      DOT_RTO
   } dot_kind_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_X,
      MUL_Y
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_SHIFT,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic [GAIN_W-1:0] alpha_gain;
      logic [GAIN_W-1:0] beta_gain;
      logic [MULT_W-1:0] variance_multiplier;
      logic [MS_W-1:0]   min_timeout_ms;
      logic [MS_W-1:0]   max_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic         load;
      logic         diff;
      dot_kind_type kind;
      mul_sel_type  mul;
      acc_op_type   acc_op;
      logic         wr_blend;
      logic         stats;
      logic         div_start;
      logic         result_load;
   } cmd_type;

   typedef struct packed {
      logic ok;
      logic est;
      logic div_done;
   } status_type;

   typedef struct packed {
      logic            accepted;
      logic            have_estimate;
      logic [MS_W-1:0] timeout_ms;
      logic [MS_W-1:0] smoothed_ms;
      logic [MS_W-1:0] variance_ms;
      logic [MS_W-1:0] last_ms;
      logic [MS_W-1:0] lowest_ms;
      logic [MS_W-1:0] highest_ms;
      logic [MS_W-1:0] mean_ms;
      logic [MS_W-1:0] samples_seen;
   } rsp_type;

   // with reversed bounds, a value below lo gives lo and any other gives hi
   function automatic logic [MS_W-1:0] clamp_ms(input logic [RAW_W-1:0] x,
                                                input logic [MS_W-1:0]  lo,
                                                input logic [MS_W-1:0]  hi);
      logic [MS_W-1:0] r;
      if (x < RAW_W'(lo)) begin
         r = lo;
      end else if (x > RAW_W'(hi)) begin
         r = hi;
      end else begin
         r = x[MS_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/rtte_div.sv */
// ----------------------------------------------------------------------------
// rtte_div
// Restoring 64 by 32 bit divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtte_div
   import rtte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] dividend,
   input  logic [MS_W-1:0]    divisor,
   output logic [TOTAL_W-1:0] quotient,
   output logic               done
);

   logic [MS_W-1:0]      rem_ff, rem_in;
   logic [TOTAL_W-1:0]   quo_ff, quo_in;
   logic [MS_W-1:0]      den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MS_W:0]        trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[TOTAL_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the difference fits
         rem_in = fits ? MS_W'(trial - {1'b0, den_ff}) : trial[MS_W-1:0];
         quo_in = {quo_ff[TOTAL_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* hw/rtl/rtte_datapath.sv */
// ----------------------------------------------------------------------------
// rtte_datapath
// Estimator state, shared 16x17 multiply-accumulate, statistics and result
// ----------------------------------------------------------------------------
module rtte_datapath
   import rtte_pkg::*;
#(
   parameter  int FRAC_BITS = 16,
   localparam int SW        = MS_W + FRAC_BITS,
   localparam int NCH       = (SW + MUL_CHUNK - 1) / MUL_CHUNK,
   localparam int CIDX_W    = $clog2(NCH)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic [MS_W-1:0]   req_sample_ms,
   input  logic              req_sample_valid,
   input  cmd_type           cmd,
   input  logic [CIDX_W-1:0] chunk_sel,
   output status_type        st,
   output rsp_type           rsp
);

   localparam int PADW  = NCH * MUL_CHUNK;
   localparam int ACC_W = SW + GAIN_W;

   logic [MS_W-1:0]    s_ff, s_in;
   logic               ok_ff, ok_in;
   logic [SW-1:0]      diff_ff, diff_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [SW-1:0]      srtt_ff, srtt_in;
   logic [SW-1:0]      var_ff, var_in;
   logic               est_ff, est_in;
   logic [MS_W-1:0]    last_ff, last_in;
   logic [MS_W-1:0]    low_ff, low_in;
   logic [MS_W-1:0]    high_ff, high_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [MS_W-1:0]    tally_ff, tally_in;
   rsp_type            rsp_ff, rsp_in;

   logic [SW-1:0]        sq;
   logic [GAIN_W-1:0]    ga, gb;
   logic [SW-1:0]        op_x, op_y;
   logic [GAIN_W-1:0]    coef_x, coef_y;
   logic [PADW-1:0]      x_pad, y_pad;
   logic [MUL_CHUNK-1:0] mul_a;
   logic [GAIN_W-1:0]    mul_b;
   logic [SW-1:0]        blend;
   logic [TOTAL_W:0]     total_sum;
   logic [TOTAL_W-1:0]   quotient;
   logic                 div_done;
   logic [RAW_W-1:0]     rto_raw;

   rtte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (total_ff),
      .divisor  (tally_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign sq = {s_ff, {FRAC_BITS{1'b0}}};
   assign ga = (cfg.alpha_gain > GAIN_ONE) ? GAIN_ONE : cfg.alpha_gain;
   assign gb = (cfg.beta_gain > GAIN_ONE) ? GAIN_ONE : cfg.beta_gain;

   // operand pairs: result = x * coef_x + y * coef_y
   always_comb begin
      case (cmd.kind)
         DOT_VAR: begin
            op_x   = var_ff;
            coef_x = GAIN_ONE - gb;
            op_y   = diff_ff;
            coef_y = gb;
         end
         DOT_SRTT: begin
            op_x   = srtt_ff;
            coef_x = GAIN_ONE - ga;
            op_y   = sq;
            coef_y = ga;
         end
         default: begin
            op_x   = srtt_ff;
            coef_x = SMOOTH_SCALE;
            op_y   = var_ff;
            coef_y = GAIN_W'(cfg.variance_multiplier);
         end
      endcase
   end

   assign x_pad = PADW'(op_x);
   assign y_pad = PADW'(op_y);
   assign mul_a = (cmd.mul == MUL_Y) ? y_pad[chunk_sel*MUL_CHUNK +: MUL_CHUNK]
                                     : x_pad[chunk_sel*MUL_CHUNK +: MUL_CHUNK];
   assign mul_b = (cmd.mul == MUL_Y) ? coef_y : coef_x;

   assign blend     = acc_ff[GAIN_FRAC +: SW];
   assign rto_raw   = acc_ff[FRAC_BITS + MULT_FRAC +: RAW_W];
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(s_ff);

   always_comb begin
      s_in     = s_ff;
      ok_in    = ok_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      srtt_in  = srtt_ff;
      var_in   = var_ff;
      est_in   = est_ff;
      last_in  = last_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      total_in = total_ff;
      tally_in = tally_ff;

      if (cmd.load) begin
         s_in  = req_sample_ms;
         ok_in = req_sample_valid;
      end
      if (cmd.diff) begin
         diff_in = (srtt_ff >= sq) ? (srtt_ff - sq) : (sq - srtt_ff);
      end
      if (cmd.mul != MUL_NONE) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      case (cmd.acc_op)
         ACC_CLEAR: acc_in = '0;
         ACC_SHIFT: acc_in = acc_ff << MUL_CHUNK;
         ACC_ADD:   acc_in = acc_ff + ACC_W'(prod_ff);
         default:   acc_in = acc_ff;
      endcase

      if (cmd.wr_blend) begin
         if (cmd.kind == DOT_VAR) begin
            var_in = blend;
         end else if (cmd.kind == DOT_SRTT) begin
            srtt_in = blend;
         end
      end

      if (cmd.stats) begin
         if (!est_ff) begin
            // first word seeds the estimate
            srtt_in = sq;
            var_in  = sq >> 1;
            low_in  = s_ff;
            high_in = s_ff;
         end else begin
            if (s_ff < low_ff) begin
               low_in = s_ff;
            end
            if (s_ff > high_ff) begin
               high_in = s_ff;
            end
         end
         est_in   = 1'b1;
         last_in  = s_ff;
         total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
         if (tally_ff != '1) begin
            tally_in = tally_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in.accepted      = ok_ff;
      rsp_in.have_estimate = est_ff;
      if (est_ff) begin
         rsp_in.timeout_ms  = clamp_ms(rto_raw, cfg.min_timeout_ms, cfg.max_timeout_ms);
         rsp_in.smoothed_ms = clamp_ms(RAW_W'(srtt_ff[FRAC_BITS +: MS_W]),
                                       cfg.min_timeout_ms, cfg.max_timeout_ms);
         rsp_in.variance_ms = clamp_ms(RAW_W'(var_ff[FRAC_BITS +: MS_W]),
                                       cfg.min_timeout_ms, cfg.max_timeout_ms);
      end else begin
         rsp_in.timeout_ms  = cfg.min_timeout_ms;
         rsp_in.smoothed_ms = '0;
         rsp_in.variance_ms = '0;
      end
      rsp_in.last_ms    = last_ff;
      rsp_in.lowest_ms  = low_ff;
      rsp_in.highest_ms = high_ff;
      if (tally_ff == '0) begin
         rsp_in.mean_ms = '0;
      end else if (quotient[TOTAL_W-1:MS_W] != '0) begin
         rsp_in.mean_ms = '1;
      end else begin
         rsp_in.mean_ms = quotient[MS_W-1:0];
      end
      rsp_in.samples_seen = tally_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff  <= '0;
         var_ff   <= '0;
         est_ff   <= 1'b0;
         last_ff  <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
         total_ff <= '0;
         tally_ff <= '0;
      end else begin
         srtt_ff  <= srtt_in;
         var_ff   <= var_in;
         est_ff   <= est_in;
         last_ff  <= last_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         total_ff <= total_in;
         tally_ff <= tally_in;
      end
      s_ff    <= s_in;
      ok_ff   <= ok_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.result_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign st.ok       = ok_ff;
   assign st.est      = est_ff;
   assign st.div_done = div_done;
   assign rsp         = rsp_ff;

endmodule

/* hw/rtl/rtte_ctrl.sv */
// ----------------------------------------------------------------------------
// rtte_ctrl
// Sequencer for the estimator: update passes, timeout pass, mean, result
// ----------------------------------------------------------------------------
module rtte_ctrl
   import rtte_pkg::*;
#(
   parameter  int FRAC_BITS = 16,
   localparam int SW        = MS_W + FRAC_BITS,
   localparam int NCH       = (SW + MUL_CHUNK - 1) / MUL_CHUNK,
   localparam int CIDX_W    = $clog2(NCH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  status_type        st,
   output cmd_type           cmd,
   output logic [CIDX_W-1:0] chunk_sel
);

   localparam logic [CIDX_W-1:0] TOP_CHUNK = CIDX_W'(NCH - 1);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      DOT,
      WRITE,
      STATS,
      START_OUT,
      WAIT_DIV,
      RESULT
   } state_type;

   typedef enum logic [1:0] {
      PH_X,
      PH_Y,
      PH_SUM
   } phase_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   dot_kind_type      kind_ff, kind_in;
   logic [CIDX_W-1:0] chunk_ff, chunk_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      cmd             = '0;
      cmd.kind        = kind_ff;
      cmd.mul         = MUL_NONE;
      cmd.acc_op      = ACC_HOLD;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            cmd.diff = 1'b1;
            if (!st.ok) begin
               state_in = START_OUT;
            end else if (!st.est) begin
               state_in = STATS;
            end else begin
               kind_in  = DOT_VAR;
               chunk_in = TOP_CHUNK;
               phase_in = PH_X;
               state_in = DOT;
            end
         end
         DOT: begin
            // most significant chunk first, accumulator shifts between chunks
            unique case (phase_ff)
               PH_X: begin
                  cmd.mul    = MUL_X;
                  cmd.acc_op = (chunk_ff == TOP_CHUNK) ? ACC_CLEAR : ACC_SHIFT;
                  phase_in   = PH_Y;
               end
               PH_Y: begin
                  cmd.mul    = MUL_Y;
                  cmd.acc_op = ACC_ADD;
                  phase_in   = PH_SUM;
               end
               default: begin
                  cmd.acc_op = ACC_ADD;
                  phase_in   = PH_X;
                  if (chunk_ff == '0) begin
                     state_in = WRITE;
                  end else begin
                     chunk_in = chunk_ff - 1'b1;
                  end
               end
            endcase
         end
         WRITE: begin
            unique case (kind_ff)
               DOT_VAR: begin
                  cmd.wr_blend = 1'b1;
                  kind_in      = DOT_SRTT;
                  chunk_in     = TOP_CHUNK;
                  phase_in     = PH_X;
                  state_in     = DOT;
               end
               DOT_SRTT: begin
                  cmd.wr_blend = 1'b1;
                  state_in     = STATS;
               end
               default: begin
                  // timeout sum stays in the accumulator
                  state_in = WAIT_DIV;
               end
            endcase
         end
         STATS: begin
            cmd.stats = 1'b1;
            state_in  = START_OUT;
         end
         START_OUT: begin
            cmd.div_start = 1'b1;
            if (st.est) begin
               kind_in  = DOT_RTO;
               chunk_in = TOP_CHUNK;
               phase_in = PH_X;
               state_in = DOT;
            end else begin
               state_in = WAIT_DIV;
            end
         end
         WAIT_DIV: begin
            if (st.div_done) begin
               state_in = RESULT;
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         phase_ff     <= PH_X;
         kind_ff      <= DOT_VAR;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign chunk_sel = chunk_ff;

endmodule

/* hw/rtl/rtt_timeout_estimator.sv */
// ----------------------------------------------------------------------------
// rtt_timeout_estimator
// Smoothed round-trip time and retransmission timeout estimator
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   req     | req_valid/req_ready, sample word | in
//   rsp     | rsp_valid/rsp_ready, figures     | out
//   csr     | csr_write_en, index, data        | in
//
// Every word runs the mean divider, which has 64 steps; a valid word after the
// first also runs two blend passes of N = ceil((32+FRAC_BITS)/16) chunks on the
// shared 16x17 multiplier, and the timeout pass runs under the divider. The next
// word can be taken in the cycle after the result is loaded. A word waits in its
// last step while the previous result waits for rsp_ready. Synchronous reset
// clears all estimates.
// ----------------------------------------------------------------------------
`include "rtt_timeout_estimator_assert.svh"

module rtt_timeout_estimator
   import rtte_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MS_W-1:0]       req_sample_ms,
   input  logic                  req_sample_valid,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_accepted,
   output logic                  rsp_have_estimate,
   output logic [MS_W-1:0]       rsp_timeout_ms,
   output logic [MS_W-1:0]       rsp_smoothed_ms,
   output logic [MS_W-1:0]       rsp_variance_ms,
   output logic [MS_W-1:0]       rsp_last_ms,
   output logic [MS_W-1:0]       rsp_lowest_ms,
   output logic [MS_W-1:0]       rsp_highest_ms,
   output logic [MS_W-1:0]       rsp_mean_ms,
   output logic [MS_W-1:0]       rsp_samples_seen,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW     = MS_W + FRAC_BITS;
   localparam int NCH    = (SW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int CIDX_W = $clog2(NCH);

   cfg_type           cfg_ff, cfg_in;
   cmd_type           cmd;
   status_type        st;
   rsp_type           rsp;
   logic [CIDX_W-1:0] chunk_sel;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ALPHA_GAIN:  cfg_in.alpha_gain          = csr_wdata[GAIN_W-1:0];
            CSR_BETA_GAIN:   cfg_in.beta_gain           = csr_wdata[GAIN_W-1:0];
            CSR_VAR_MULT:    cfg_in.variance_multiplier = csr_wdata[MULT_W-1:0];
            CSR_MIN_TIMEOUT: cfg_in.min_timeout_ms      = csr_wdata[MS_W-1:0];
            CSR_MAX_TIMEOUT: cfg_in.max_timeout_ms      = csr_wdata[MS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_gain          <= ALPHA_RESET;
         cfg_ff.beta_gain           <= BETA_RESET;
         cfg_ff.variance_multiplier <= MULT_RESET;
         cfg_ff.min_timeout_ms      <= MIN_RESET;
         cfg_ff.max_timeout_ms      <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rtte_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd),
      .chunk_sel (chunk_sel)
   );

   rtte_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_sample_ms    (req_sample_ms),
      .req_sample_valid (req_sample_valid),
      .cmd              (cmd),
      .chunk_sel        (chunk_sel),
      .st               (st),
      .rsp              (rsp)
   );

   assign rsp_accepted      = rsp.accepted;
   assign rsp_have_estimate = rsp.have_estimate;
   assign rsp_timeout_ms    = rsp.timeout_ms;
   assign rsp_smoothed_ms   = rsp.smoothed_ms;
   assign rsp_variance_ms   = rsp.variance_ms;
   assign rsp_last_ms       = rsp.last_ms;
   assign rsp_lowest_ms     = rsp.lowest_ms;
   assign rsp_highest_ms    = rsp.highest_ms;
   assign rsp_mean_ms       = rsp.mean_ms;
   assign rsp_samples_seen  = rsp.samples_seen;

   // one word in flight at a time
   `RTTE_ASSERT_NXT(a_single_word, clock, reset, req_valid && req_ready, !req_ready, "word taken while busy")

   `RTTE_ASSERT_IMP(a_accept_has_est, clock, reset, rsp_valid && rsp_accepted, rsp_have_estimate, "accepted sample without estimate")

   `RTTE_ASSERT_IMP(a_no_est_no_stats, clock, reset, rsp_valid && !rsp_have_estimate, rsp_samples_seen == '0 && rsp_mean_ms == '0, "statistics before first sample")

   `RTTE_ASSERT_IMP(a_range_order, clock, reset, rsp_valid && rsp_have_estimate, rsp_lowest_ms <= rsp_highest_ms, "lowest sample above highest")

endmodule
